// ----- src/tsp_pkg.sv -----
package tsp_pkg;

	// Sequencer states of the step planner.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DIST,
		S_PROG,
		S_MUL,
		S_DIV1,
		S_SPEED,
		S_MODE,
		S_DIV2,
		S_LOW,
		S_POS,
		S_ARR,
		S_DONE
	} tsp_state_t;

	// Register indexes on the configuration port (word address).
	localparam logic [2:0] REG_MIN_RPM    = 3'd0;
	localparam logic [2:0] REG_MAX_RPM    = 3'd1;
	localparam logic [2:0] REG_RAMP_STEPS = 3'd2;
	localparam logic [2:0] REG_STEP_TC    = 3'd3;
	localparam logic [2:0] REG_PULSE_HIGH = 3'd4;
	localparam logic [2:0] REG_MS_ENABLE  = 3'd5;
	localparam logic [2:0] REG_CW_POS     = 3'd6;

	// Register reset values.
	localparam logic [15:0] RST_MIN_RPM    = 16'd160;
	localparam logic [15:0] RST_MAX_RPM    = 16'd9600;
	localparam logic [15:0] RST_RAMP_STEPS = 16'd800;
	localparam logic [23:0] RST_STEP_TC    = 24'd300000;
	localparam logic [15:0] RST_PULSE_HIGH = 16'd2;

	localparam logic [19:0] LOW_TIME_MAX = 20'd1000000;

	// Serial arithmetic sizes.
	localparam int MUL_W      = 16;
	localparam int CNT_W      = 5;
	localparam int DIV_DVD_W  = 28;
	localparam int DIV_DSR_W  = 20;
	localparam logic [CNT_W-1:0] MUL_STEPS  = 5'd16;
	localparam logic [CNT_W-1:0] DIV1_STEPS = 5'd16;
	localparam logic [CNT_W-1:0] DIV2_STEPS = 5'd28;

	// Microstep shift: the step divisor is 1 << shift.
	localparam logic [2:0] SH_FULL      = 3'd0;
	localparam logic [2:0] SH_HALF      = 3'd1;
	localparam logic [2:0] SH_QUARTER   = 3'd2;
	localparam logic [2:0] SH_EIGHTH    = 3'd3;
	localparam logic [2:0] SH_SIXTEENTH = 3'd4;

	// Mode pin codes, ms3 ms2 ms1.
	localparam logic [2:0] MODE_FULL      = 3'b000;
	localparam logic [2:0] MODE_HALF      = 3'b001;
	localparam logic [2:0] MODE_QUARTER   = 3'b010;
	localparam logic [2:0] MODE_EIGHTH    = 3'b011;
	localparam logic [2:0] MODE_SIXTEENTH = 3'b111;

	// Request to the serial divider.
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} tsp_div_req_t;

	function automatic logic [2:0] mode_code(input logic [2:0] sh);
		logic [2:0] m;
		case (sh)
			SH_HALF:      m = MODE_HALF;
			SH_QUARTER:   m = MODE_QUARTER;
			SH_EIGHTH:    m = MODE_EIGHTH;
			SH_SIXTEENTH: m = MODE_SIXTEENTH;
			default:      m = MODE_FULL;
		endcase
		return m;
	endfunction

endpackage

// ----- src/tsp_mul_serial.sv -----
module tsp_mul_serial import tsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   prod,
	output logic                 done
);

	logic [MUL_W-1:0]   a_q;
	logic [2*MUL_W-1:0] prod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     sum;

	// One multiplier bit per cycle: add into the upper half, shift right.
	assign sum = {1'b0, prod_q[2*MUL_W-1:MUL_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= MUL_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MUL_W-1:1]};
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ----- src/tsp_div_serial.sv -----
module tsp_div_serial import tsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsp_div_req_t         req,
	input  logic [DIV_DSR_W-1:0] rem_init,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DSR_W-1:0] divisor,
	output logic [DIV_DVD_W-1:0] quotient,
	output logic                 done
);

	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVD_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DSR_W:0]   trial;
	logic [DIV_DSR_W+1:0] diff;

	// Restoring division, one quotient bit per cycle. The remainder stays
	// below the divisor, so it fits the divisor width.
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem_init;
			dsr_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			if (!diff[DIV_DSR_W+1]) begin
				rem_q <= diff[DIV_DSR_W-1:0];
				quo_q <= {quo_q[DIV_DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DSR_W-1:0];
				quo_q <= {quo_q[DIV_DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- src/stepper_trapezoid_step_planner.sv -----
// Each item runs in order: distance and ramp length, then on a ramp the serial multiplier
// and a first division on the shared divider, then the speed, the microstep mode, a second
// division for the low time, the new position and the arrival check. A preset or an already
// arrived item goes straight to the result. One item at a time; a step at zero speed skips
// the second division. A result still waiting at the output holds back the next one and stalls input.
// Reset (arst_n low, asynchronous) clears the position, selects positive direction and full step.
module stepper_trapezoid_step_planner import tsp_pkg::*; #(
	parameter int unsigned SIXTEENTH_LIMIT = 960,
	parameter int unsigned EIGHTH_LIMIT    = 1920,
	parameter int unsigned QUARTER_LIMIT   = 3840,
	parameter int unsigned HALF_LIMIT      = 7680
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_position [23:0], target_position [47:24], preset_value [71:48]
	input  logic [71:0] s_tdata,
	// preset [0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// dir_level [0], mode_pins [3:1], low_time_us [23:4], speed_rpm [39:24],
	// new_position [63:40]
	output logic [63:0] m_tdata,
	// step_made [0]
	output logic [0:0]  m_tuser,
	// arrived
	output logic        m_tlast
);

	tsp_state_t state_q, state_nx;

	// Configuration registers.
	logic [15:0] min_rpm_q, max_rpm_q, ramp_steps_q, pulse_high_q;
	logic [23:0] stc_q;
	logic        ms_en_q, cw_pos_q;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	// Planner state.
	logic signed [23:0] pos_q;
	logic               dir_q;
	logic [2:0]         div_sh_q;

	// Item registers.
	logic signed [23:0] s_q, t_q, pv_q;
	logic               preset_q;
	logic               pos_dir_q;
	logic [15:0]        ramp_q;
	logic               diff_neg_q;
	logic [15:0]        speed_q;
	logic signed [23:0] res_pos_q;
	logic [19:0]        res_low_q;
	logic               res_step_q, res_arr_q;

	logic        m_tvalid_q, m_tlast_q;
	logic [63:0] m_tdata_q;
	logic [0:0]  m_tuser_q;

	// Control outputs.
	logic in_take, out_load, mul_start;
	tsp_div_req_t         div_req;
	logic [DIV_DSR_W-1:0] div_rem_init, div_divisor;
	logic [DIV_DVD_W-1:0] div_dividend, div_quo;
	logic                 div_done, mul_done;
	logic [2*MUL_W-1:0]   mul_prod;

	// Distance and ramp length.
	logic               pos_dir, arr_now, dist_small;
	logic signed [24:0] st_diff;
	logic [23:0]        move_len;
	logic [15:0]        ramp;

	// Ramp progress.
	logic signed [25:0] s_x, t_x, p_x, r_x, pr1, pr2, prog_raw;
	logic               c1, c2, use_ramp, diff_neg;
	logic [15:0]        prog, diff_mag;

	// Speed, mode, low time, step.
	logic [2:0]  new_sh;
	logic [28:0] q_sub;
	logic [27:0] q_low;
	logic [4:0]  delta;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rpm_q    <= RST_MIN_RPM;
			max_rpm_q    <= RST_MAX_RPM;
			ramp_steps_q <= RST_RAMP_STEPS;
			stc_q        <= RST_STEP_TC;
			pulse_high_q <= RST_PULSE_HIGH;
			ms_en_q      <= 1'b1;
			cw_pos_q     <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MIN_RPM:    min_rpm_q    <= pwdata[15:0];
				REG_MAX_RPM:    max_rpm_q    <= pwdata[15:0];
				REG_RAMP_STEPS: ramp_steps_q <= pwdata[15:0];
				REG_STEP_TC:    stc_q        <= pwdata[23:0];
				REG_PULSE_HIGH: pulse_high_q <= pwdata[15:0];
				REG_MS_ENABLE:  ms_en_q      <= pwdata[0];
				REG_CW_POS:     cw_pos_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_RPM:    prdata = {16'd0, min_rpm_q};
			REG_MAX_RPM:    prdata = {16'd0, max_rpm_q};
			REG_RAMP_STEPS: prdata = {16'd0, ramp_steps_q};
			REG_STEP_TC:    prdata = {8'd0, stc_q};
			REG_PULSE_HIGH: prdata = {16'd0, pulse_high_q};
			REG_MS_ENABLE:  prdata = {31'd0, ms_en_q};
			REG_CW_POS:     prdata = {31'd0, cw_pos_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Move direction, arrival before stepping, and ramp length.
	always_comb begin
		pos_dir    = s_q < t_q;
		arr_now    = pos_dir ? (pos_q >= t_q) : (pos_q <= t_q);
		st_diff    = pos_dir ? ({t_q[23], t_q} - {s_q[23], s_q})
		                     : ({s_q[23], s_q} - {t_q[23], t_q});
		move_len   = st_diff[23:0];
		dist_small = move_len < {7'd0, ramp_steps_q, 1'b0};
		ramp       = dist_small ? move_len[16:1] : ramp_steps_q;
	end

	// Ramp progress, measured from whichever end of the move is near.
	always_comb begin
		s_x = {{2{s_q[23]}}, s_q};
		t_x = {{2{t_q[23]}}, t_q};
		p_x = {{2{pos_q[23]}}, pos_q};
		r_x = {10'd0, ramp_q};
		if (pos_dir_q) begin
			c1  = p_x < s_x + r_x;
			c2  = p_x > t_x - r_x;
			pr1 = p_x - s_x;
			pr2 = t_x - p_x;
		end else begin
			c1  = p_x > s_x - r_x;
			c2  = p_x < t_x + r_x;
			pr1 = s_x - p_x;
			pr2 = p_x - t_x;
		end
		prog_raw = c1 ? pr1 : pr2;
		// Progress stays below the ramp length, so 16 bits hold it.
		prog     = prog_raw[25] ? 16'd0 : prog_raw[15:0];
		use_ramp = (c1 || c2) && (ramp_steps_q != 16'd0);
		diff_neg = min_rpm_q > max_rpm_q;
		diff_mag = diff_neg ? (min_rpm_q - max_rpm_q) : (max_rpm_q - min_rpm_q);
	end

	// Microstep selection from the speed of this step.
	always_comb begin
		priority if (!ms_en_q)                           new_sh = SH_FULL;
		else if (speed_q <= 16'(SIXTEENTH_LIMIT))        new_sh = SH_SIXTEENTH;
		else if (speed_q <= 16'(EIGHTH_LIMIT))           new_sh = SH_EIGHTH;
		else if (speed_q <= 16'(QUARTER_LIMIT))          new_sh = SH_QUARTER;
		else if (speed_q <= 16'(HALF_LIMIT))             new_sh = SH_HALF;
		else                                             new_sh = SH_FULL;
	end

	assign q_sub = {1'b0, div_quo} - {13'd0, pulse_high_q};
	assign q_low = q_sub[28] ? 28'd0 : q_sub[27:0];
	assign delta = 5'd16 >> div_sh_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_nx = S_DIST;
			S_DIST:  state_nx = (preset_q || arr_now) ? S_DONE : S_PROG;
			S_PROG:  state_nx = use_ramp ? S_MUL : S_MODE;
			S_MUL:   if (mul_done) state_nx = S_DIV1;
			S_DIV1:  if (div_done) state_nx = S_SPEED;
			S_SPEED: state_nx = S_MODE;
			S_MODE:  state_nx = (speed_q == 16'd0) ? S_POS : S_DIV2;
			S_DIV2:  if (div_done) state_nx = S_LOW;
			S_LOW:   state_nx = S_POS;
			S_POS:   state_nx = S_ARR;
			S_ARR:   state_nx = S_DONE;
			S_DONE:  if (!m_tvalid_q || m_tready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Control outputs and the operands of the shared divider.
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		in_take   = s_tready && s_tvalid;
		out_load  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
		mul_start = (state_q == S_PROG) && use_ramp;
		div_req.start = ((state_q == S_MUL) && mul_done) ||
		                ((state_q == S_MODE) && (speed_q != 16'd0));
		if (state_q == S_MUL) begin
			// The product is below ramp_steps * 2^16, so its upper half
			// is a valid starting remainder and 16 steps suffice.
			div_req.steps = DIV1_STEPS;
			div_rem_init  = {4'd0, mul_prod[31:16]};
			div_dividend  = {mul_prod[15:0], 12'd0};
			div_divisor   = {4'd0, ramp_steps_q};
		end else begin
			div_req.steps = DIV2_STEPS;
			div_rem_init  = '0;
			div_dividend  = {stc_q, 4'd0};
			div_divisor   = {4'd0, speed_q} << new_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_q      <= '0;
			dir_q      <= 1'b1;
			div_sh_q   <= SH_FULL;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_MODE) begin
				dir_q    <= pos_dir_q;
				div_sh_q <= new_sh;
			end
			if (out_load) begin
				pos_q      <= res_pos_q;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			s_q      <= s_tdata[23:0];
			t_q      <= s_tdata[47:24];
			pv_q     <= s_tdata[71:48];
			preset_q <= s_tuser[0];
		end
		unique case (state_q)
			S_DIST: begin
				pos_dir_q  <= pos_dir;
				ramp_q     <= ramp;
				res_step_q <= 1'b0;
				res_low_q  <= '0;
				speed_q    <= '0;
				res_pos_q  <= preset_q ? pv_q : pos_q;
				res_arr_q  <= !preset_q;
			end
			S_PROG: begin
				diff_neg_q <= diff_neg;
				if (!use_ramp) speed_q <= max_rpm_q;
			end
			S_SPEED: begin
				speed_q <= diff_neg_q ? (min_rpm_q - div_quo[15:0])
				                      : (min_rpm_q + div_quo[15:0]);
			end
			S_MODE: begin
				if (speed_q == 16'd0) res_low_q <= LOW_TIME_MAX;
			end
			S_LOW: begin
				res_low_q <= (q_low > {8'd0, LOW_TIME_MAX}) ? LOW_TIME_MAX : q_low[19:0];
			end
			S_POS: begin
				res_step_q <= 1'b1;
				res_pos_q  <= pos_dir_q ? (pos_q + {19'd0, delta}) : (pos_q - {19'd0, delta});
			end
			S_ARR: begin
				res_arr_q <= pos_dir_q ? (res_pos_q >= t_q) : (res_pos_q <= t_q);
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= {res_pos_q, res_step_q ? speed_q : 16'd0, res_low_q,
			              mode_code(div_sh_q), dir_q == cw_pos_q};
			m_tuser_q <= res_step_q;
			m_tlast_q <= res_arr_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	tsp_mul_serial u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (diff_mag),
		.b      (prog),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	tsp_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem_init),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

endmodule

// ----- src/tsp_checker.sv -----
module tsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item at a time: right after an input transfer the input is closed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open right after a transfer");

	// An item without a step carries no speed and no low time.
	a_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[39:4] == 36'd0)
		else $error("speed or low time on an item without a step");

	// The low time stays within its clamp.
	a_low_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:4] <= 20'd1000000)
		else $error("low time above its limit");

	// A step at zero speed waits the longest low time.
	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tdata[39:24] == 16'd0 |->
			m_tdata[23:4] == 20'd1000000)
		else $error("zero speed step without the longest low time");

endmodule

bind stepper_trapezoid_step_planner tsp_checker u_tsp_checker (.*);
